// ===== rtl/plfc_pkg.sv =====
// Package for the Playfair encryptor core: widths, opcodes, ASCII constants,
// and the command and status types shared by the front end, queue and back end.
// Depends on nothing.
package plfc_pkg;

  localparam int SQUARE_SIDE = 5;
  localparam int CELL_COUNT  = SQUARE_SIDE * SQUARE_SIDE;
  localparam int LETTERS     = 26;
  localparam int LETTER_W    = 5;
  localparam int POS_W       = $clog2(SQUARE_SIDE + 1);
  localparam int CELL_W      = $clog2(CELL_COUNT);
  localparam int BYTE_W      = 8;
  localparam int OPCODE_W    = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

  localparam logic [LETTER_W-1:0] LETTER_I      = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J      = 5'd9;
  localparam logic [LETTER_W-1:0] FILLER_RESET  = 5'd25;

  localparam logic [BYTE_W-1:0] ASCII_A        = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_Z        = 8'h5A;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_A  = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_LOWER_Z  = 8'h7A;
  localparam logic [BYTE_W-1:0] ASCII_CASE_GAP = 8'd32;

  localparam logic [OPCODE_W-1:0] OP_START_KEY = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_KEY_BYTE  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_END_KEY   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PLAINTEXT = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_END_MSG   = 3'd4;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_PLACE,
    CMD_END_KEY,
    CMD_PAIR
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [LETTER_W-1:0] a;
    logic [LETTER_W-1:0] b;
  } cmd_t;

  typedef struct packed {
    logic                pending_valid;
    logic [LETTER_W-1:0] filler;
  } front_stat_t;

endpackage

// ===== rtl/plfc_front.sv =====
// Front end of the Playfair encryptor: folds input bytes to letters, pairs the
// plaintext with filler letters, and issues commands to the queue.
// Depends on plfc_pkg.
module plfc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [plfc_pkg::BYTE_W-1:0]   s_tdata_i,
  input  logic [plfc_pkg::OPCODE_W-1:0] s_tuser_i,
  output logic                          push_valid_o,
  output plfc_pkg::cmd_t                push_data_o,
  input  logic                          push_ready_i,
  output plfc_pkg::front_stat_t         stat_o
);
  import plfc_pkg::*;

  function automatic logic [LETTER_W:0] fold_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0]   u;
    logic [LETTER_W-1:0] l;
    logic                ok;
    u = b;
    if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
      u = b - ASCII_CASE_GAP;
    end
    ok = (u >= ASCII_A) && (u <= ASCII_Z);
    l  = LETTER_W'(u - ASCII_A);
    if (l == LETTER_J) begin
      l = LETTER_I;
    end
    return {ok, l};
  endfunction

  function automatic logic [LETTER_W-1:0] next_filler(input logic [LETTER_W-1:0] c);
    logic [LETTER_W-1:0] n;
    n = c + 1'b1;
    if (n == LETTER_J) begin
      n = n + 1'b1;
    end
    if (n >= LETTER_W'(LETTERS)) begin
      n = n - LETTER_W'(LETTERS);
    end
    return n;
  endfunction

  logic [LETTER_W-1:0] pend_q, pend_d;
  logic                pv_q, pv_d;
  logic [LETTER_W-1:0] cnt_q, cnt_d;
  logic [LETTER_W:0]   folded;
  logic                letter_ok;
  logic [LETTER_W-1:0] letter;
  logic [LETTER_W-1:0] fill1, fill2, filler;
  logic                accept;
  logic                push_req;

  assign folded    = fold_byte(s_tdata_i);
  assign letter_ok = folded[LETTER_W];
  assign letter    = folded[LETTER_W-1:0];
  assign fill1     = next_filler(cnt_q);
  assign fill2     = next_filler(fill1);
  assign filler    = (fill1 == pend_q) ? fill2 : fill1;

  assign s_tready_o   = push_ready_i;
  assign accept       = s_tvalid_i && push_ready_i;
  assign push_valid_o = accept && push_req;

  always_comb begin
    pend_d          = pend_q;
    pv_d            = pv_q;
    cnt_d           = cnt_q;
    push_req        = 1'b0;
    push_data_o.cmd = CMD_START;
    push_data_o.a   = letter;
    push_data_o.b   = letter;
    case (s_tuser_i)
      OP_START_KEY: begin
        push_req = 1'b1;
        pv_d     = 1'b0;
        cnt_d    = FILLER_RESET;
      end
      OP_KEY_BYTE: begin
        push_req        = letter_ok;
        push_data_o.cmd = CMD_PLACE;
      end
      OP_END_KEY: begin
        push_req        = 1'b1;
        push_data_o.cmd = CMD_END_KEY;
      end
      OP_PLAINTEXT: begin
        push_data_o.cmd = CMD_PAIR;
        push_data_o.a   = pend_q;
        if (letter_ok) begin
          if (!pv_q) begin
            pend_d = letter;
            pv_d   = 1'b1;
          end else if (letter != pend_q) begin
            push_req = 1'b1;
            pv_d     = 1'b0;
          end else begin
            push_req      = 1'b1;
            push_data_o.b = filler;
            cnt_d         = filler;
          end
        end
      end
      OP_END_MSG: begin
        push_data_o.cmd = CMD_PAIR;
        push_data_o.a   = pend_q;
        push_data_o.b   = filler;
        if (pv_q) begin
          push_req = 1'b1;
          cnt_d    = filler;
          pv_d     = 1'b0;
        end
      end
      default: begin
        push_req = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pv_q   <= 1'b0;
      cnt_q  <= FILLER_RESET;
    end else if (accept) begin
      pend_q <= pend_d;
      pv_q   <= pv_d;
      cnt_q  <= cnt_d;
    end
  end

  assign stat_o.pending_valid = pv_q;
  assign stat_o.filler        = cnt_q;

endmodule

// ===== rtl/plfc_fifo.sv =====
// Short command queue between the front end and the back end of the
// Playfair encryptor. Depends on plfc_pkg.
module plfc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  plfc_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output plfc_pkg::cmd_t pop_data_o
);
  import plfc_pkg::*;

  cmd_t                  entries_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W:0]   count_q, count_d;
  logic                  do_push, do_pop;

  assign push_ready_o = (count_q != (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/plfc_back.sv =====
// Back end of the Playfair encryptor: builds the letter square from queued
// commands and turns letter pairs into cipher letters. Depends on plfc_pkg.
module plfc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  plfc_pkg::cmd_t              cmd_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [plfc_pkg::BYTE_W-1:0] m_tdata_o,
  output logic                        m_tlast_o
);
  import plfc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_OUT0 = 3'd3;
  localparam logic [2:0] S_OUT1 = 3'd4;

  function automatic logic [POS_W-1:0] inc_wrap(input logic [POS_W-1:0] x);
    return (x == POS_W'(SQUARE_SIDE - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [CELL_W-1:0] cell_index(input logic [POS_W-1:0] r,
                                                   input logic [POS_W-1:0] c);
    return CELL_W'(CELL_W'(r) * CELL_W'(SQUARE_SIDE) + CELL_W'(c));
  endfunction

  logic [LETTER_W-1:0]  sq_mem [CELL_COUNT];
  logic [2*POS_W-1:0]   rc_mem [LETTERS];

  logic [2:0]           state_q, state_d;
  logic [LETTER_W-1:0]  walk_q, walk_d;
  logic [POS_W-1:0]     fill_row_q, fill_row_d;
  logic [POS_W-1:0]     fill_col_q, fill_col_d;
  logic [LETTERS-1:0]   placed_q, placed_d;
  logic                 out_valid_q, out_valid_d;
  logic [LETTER_W-1:0]  out_letter_q, out_letter_d;
  logic                 out_last_q, out_last_d;

  logic [2*POS_W-1:0]   rc_a_q, rc_b_q;
  logic [LETTER_W-1:0]  cell_a_q, cell_b_q;
  logic                 rc_rd_en, sq_rd_en;
  logic                 place_en, place_ok;
  logic [LETTER_W-1:0]  place_v;
  logic [CELL_W-1:0]    fill_idx;
  logic [POS_W-1:0]     ar, ac, br, bc, ar_n, ac_n, br_n, bc_n;
  logic [CELL_W-1:0]    idx_a, idx_b;
  logic                 out_free;
  logic                 take;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign out_free    = !out_valid_q || m_tready_i;
  assign fill_idx    = cell_index(fill_row_q, fill_col_q);
  assign place_ok    = place_en && !placed_q[place_v] &&
                       (fill_row_q < POS_W'(SQUARE_SIDE));
  assign rc_rd_en    = take && (cmd_i.cmd == CMD_PAIR);
  assign sq_rd_en    = (state_q == S_LOOK);

  always_comb begin
    ar = rc_a_q[2*POS_W-1:POS_W];
    ac = rc_a_q[POS_W-1:0];
    br = rc_b_q[2*POS_W-1:POS_W];
    bc = rc_b_q[POS_W-1:0];
    ar_n = ar;
    ac_n = ac;
    br_n = br;
    bc_n = bc;
    if (ar == br) begin
      ac_n = inc_wrap(ac);
      bc_n = inc_wrap(bc);
    end else if (ac == bc) begin
      ar_n = inc_wrap(ar);
      br_n = inc_wrap(br);
    end else begin
      ac_n = bc;
      bc_n = ac;
    end
    idx_a = cell_index(ar_n, ac_n);
    idx_b = cell_index(br_n, bc_n);
  end

  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    fill_row_d   = fill_row_q;
    fill_col_d   = fill_col_q;
    placed_d     = placed_q;
    out_valid_d  = out_valid_q && !m_tready_i;
    out_letter_d = out_letter_q;
    out_last_d   = out_last_q;
    place_en     = 1'b0;
    place_v      = cmd_i.a;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          case (cmd_i.cmd)
            CMD_START: begin
              placed_d   = '0;
              fill_row_d = '0;
              fill_col_d = '0;
            end
            CMD_PLACE: begin
              place_en = 1'b1;
            end
            CMD_END_KEY: begin
              walk_d  = '0;
              state_d = S_WALK;
            end
            CMD_PAIR: begin
              state_d = S_LOOK;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_WALK: begin
        place_v  = walk_q;
        place_en = (walk_q != LETTER_J);
        walk_d   = walk_q + 1'b1;
        if (walk_q == LETTER_W'(LETTERS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_LOOK: begin
        state_d = S_OUT0;
      end
      S_OUT0: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_letter_d = cell_a_q;
          out_last_d   = 1'b0;
          state_d      = S_OUT1;
        end
      end
      S_OUT1: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_letter_d = cell_b_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (place_ok) begin
      placed_d[place_v] = 1'b1;
      if (fill_col_q == POS_W'(SQUARE_SIDE - 1)) begin
        fill_col_d = '0;
        fill_row_d = fill_row_q + 1'b1;
      end else begin
        fill_col_d = fill_col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      walk_q      <= '0;
      fill_row_q  <= '0;
      fill_col_q  <= '0;
      placed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      walk_q      <= walk_d;
      fill_row_q  <= fill_row_d;
      fill_col_q  <= fill_col_d;
      placed_q    <= placed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_letter_q <= out_letter_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (place_ok) begin
      sq_mem[fill_idx] <= place_v;
      rc_mem[place_v]  <= {fill_row_q, fill_col_q};
    end
    if (rc_rd_en) begin
      rc_a_q <= rc_mem[cmd_i.a];
      rc_b_q <= rc_mem[cmd_i.b];
    end
    if (sq_rd_en) begin
      cell_a_q <= sq_mem[idx_a];
      cell_b_q <= sq_mem[idx_b];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(BYTE_W - LETTER_W){1'b0}}, out_letter_q};
  assign m_tlast_o  = out_last_q;

endmodule

// ===== rtl/playfair_cipher_encryptor_core.sv =====
// Top level of the Playfair encryptor core: front end, command queue and
// back end. Depends on plfc_pkg, plfc_front, plfc_fifo and plfc_back.
//
// Each input transaction carries an opcode in tuser and an ASCII byte in tdata.
// The front end takes one transaction per cycle while its four-entry command
// queue has room. The back end takes a new command only while idle. A start
// key or key byte is handled in the accepting cycle; an end key is accepted,
// then the back end walks the alphabet letter by letter while the square is
// completed. A letter pair goes through a lookup of the two letter positions,
// a read of the two cipher cells, and one output transaction per cipher
// letter; the output transactions wait while the output is stalled. A
// plaintext byte that repeats the pending letter is paired with a filler. Output
// letters come two per pair with tlast marking the second; the first filler
// letter after a start key is A, or B when the doubled letter is A.
module playfair_cipher_encryptor_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [plfc_pkg::BYTE_W-1:0]   s_tdata_i,  // [7:0] char_byte
  input  logic [plfc_pkg::OPCODE_W-1:0] s_tuser_i,  // [2:0] opcode
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [plfc_pkg::BYTE_W-1:0]   m_tdata_o,  // [4:0] cipher_letter, [7:5] zero
  output logic                          m_tlast_o
);
  import plfc_pkg::*;

  logic        push_valid, push_ready;
  cmd_t        push_data;
  logic        pop_valid, pop_ready;
  cmd_t        pop_data;
  front_stat_t front_stat;

  plfc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_o   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready),
    .stat_o       (front_stat)
  );

  plfc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  plfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tlast_o   (m_tlast_o)
  );

  a_pair_second : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tready_i && !m_tlast_o |=> m_tvalid_o && m_tlast_o)
    else $error("Second letter of a pair did not follow the first.");

  a_pending_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_o && (s_tuser_i == OP_END_MSG || s_tuser_i == OP_START_KEY)
    |=> !front_stat.pending_valid)
    else $error("Pending letter survived an end message or start key.");

  a_filler_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_stat.filler != LETTER_J && front_stat.filler < LETTER_W'(LETTERS))
    else $error("Filler counter left the letter range or hit J.");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for playfair_cipher_encryptor_core: directed and random key and
// message traffic with bursty handshakes, checked against a square model kept in the bench.
// Depends on plfc_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plfc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
  } cipher_t;

  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [BYTE_W-1:0]   s_tdata_i  = '0;
  logic [OPCODE_W-1:0] s_tuser_i  = OP_START_KEY;
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic [BYTE_W-1:0]   m_tdata_o;
  logic                m_tlast_o;

  cipher_t cipher_q[$];
  int      error_count  = 0;
  int      items_sent   = 0;
  int      quiet_cycles = 0;
  bit      idle_on      = 1'b1;

  logic [LETTER_W-1:0] sq_cell[CELL_COUNT];
  bit                  sq_placed[LETTERS];
  int                  sq_row[LETTERS];
  int                  sq_col[LETTERS];
  int                  fill_r      = 0;
  int                  fill_c      = 0;
  int                  filler_ctr  = int'(FILLER_RESET);
  int                  held_letter = 0;
  bit                  held_valid  = 1'b0;

  playfair_cipher_encryptor_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int fold_char(logic [BYTE_W-1:0] ch);
    int b;
    b = int'(ch);
    if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) b -= int'(ASCII_CASE_GAP);
    if (b < int'(ASCII_A) || b > int'(ASCII_Z)) return -1;
    b -= int'(ASCII_A);
    if (b == int'(LETTER_J)) b = int'(LETTER_I);
    return b;
  endfunction

  function automatic void place_in_square(int v);
    if (sq_placed[v] || fill_r >= SQUARE_SIDE) return;
    sq_cell[fill_r * SQUARE_SIDE + fill_c] = LETTER_W'(v);
    sq_row[v] = fill_r;
    sq_col[v] = fill_c;
    sq_placed[v] = 1'b1;
    fill_c++;
    if (fill_c >= SQUARE_SIDE) begin
      fill_c = 0;
      fill_r++;
    end
  endfunction

  function automatic int step_filler();
    int c;
    c = filler_ctr + 1;
    if (c == int'(LETTER_J)) c++;
    if (c >= LETTERS) c -= LETTERS;
    filler_ctr = c;
    return c;
  endfunction

  function automatic int filler_for(int v);
    int c;
    c = step_filler();
    while (c == v) c = step_filler();
    return c;
  endfunction

  function automatic void encrypt_pair(int a, int b);
    int ar, ac, br, bc, t;
    ar = sq_row[a];
    ac = sq_col[a];
    br = sq_row[b];
    bc = sq_col[b];
    if (ar == br) begin
      ac = (ac + 1) % SQUARE_SIDE;
      bc = (bc + 1) % SQUARE_SIDE;
    end else if (ac == bc) begin
      ar = (ar + 1) % SQUARE_SIDE;
      br = (br + 1) % SQUARE_SIDE;
    end else begin
      t  = ac;
      ac = bc;
      bc = t;
    end
    cipher_q.push_back('{letter: sq_cell[ar * SQUARE_SIDE + ac], last: 1'b0});
    cipher_q.push_back('{letter: sq_cell[br * SQUARE_SIDE + bc], last: 1'b1});
  endfunction

  function automatic void predict_cipher(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] ch);
    int v;
    int a;
    int i;
    v = fold_char(ch);
    case (op)
      OP_START_KEY: begin
        for (i = 0; i < LETTERS; i++) sq_placed[i] = 1'b0;
        fill_r     = 0;
        fill_c     = 0;
        filler_ctr = int'(FILLER_RESET);
        held_valid = 1'b0;
      end
      OP_KEY_BYTE: begin
        if (v >= 0) place_in_square(v);
      end
      OP_END_KEY: begin
        for (i = 0; i < LETTERS; i++) if (i != int'(LETTER_J)) place_in_square(i);
      end
      OP_PLAINTEXT: begin
        if (v >= 0) begin
          if (!held_valid) begin
            held_letter = v;
            held_valid  = 1'b1;
          end else if (v != held_letter) begin
            held_valid = 1'b0;
            encrypt_pair(held_letter, v);
          end else begin
            a = held_letter;
            encrypt_pair(a, filler_for(a));
            held_letter = v;
          end
        end
      end
      OP_END_MSG: begin
        if (held_valid) begin
          held_valid = 1'b0;
          a = held_letter;
          encrypt_pair(a, filler_for(a));
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] random_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [BYTE_W-1:0] random_letter_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'(int'(ASCII_A) + $urandom_range(0, LETTERS - 1));
    if ($urandom_range(0, 1) == 1) b += ASCII_CASE_GAP;
    return b;
  endfunction

  function automatic logic [OPCODE_W-1:0] undefined_opcode();
    return OPCODE_W'($urandom_range(int'(OP_END_MSG) + 1, (1 << OPCODE_W) - 1));
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] ch);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= ch;
    s_tuser_i  <= op;
    do @(posedge clk_i); while (!s_tready_o);
    predict_cipher(op, ch);
    if (op <= OP_END_MSG &&
        !((op == OP_KEY_BYTE || op == OP_PLAINTEXT) && fold_char(ch) < 0)) begin
      items_sent++;
    end
  endtask

  task automatic hold_off_until_drained();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (cipher_q.size() != 0);
  endtask

  task automatic send_random_key();
    int n;
    send_item(OP_START_KEY, random_byte());
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) send_item(OP_KEY_BYTE, random_byte());
      else send_item(OP_KEY_BYTE, random_letter_byte());
      if ($urandom_range(0, 15) == 0) send_item(OP_PLAINTEXT, random_letter_byte());
    end
    if ($urandom_range(0, 7) != 0) send_item(OP_END_KEY, random_byte());
    if ($urandom_range(0, 4) == 0) send_item(OP_KEY_BYTE, random_letter_byte());
  endtask

  task automatic send_random_message();
    int                len;
    logic [BYTE_W-1:0] prev;
    logic [BYTE_W-1:0] ch;
    len  = $urandom_range(1, 24);
    prev = random_letter_byte();
    repeat (len) begin
      case ($urandom_range(0, 9))
        0, 1, 2: ch = prev;
        3:       ch = random_byte();
        default: ch = random_letter_byte();
      endcase
      send_item(OP_PLAINTEXT, ch);
      prev = ch;
    end
    if ($urandom_range(0, 5) != 0) send_item(OP_END_MSG, random_byte());
  endtask

  task automatic test_directed_cases();
    send_item(OP_START_KEY, 8'hFF);
    send_item(OP_KEY_BYTE, "k");
    send_item(OP_KEY_BYTE, "J");
    send_item(OP_KEY_BYTE, "e");
    send_item(OP_KEY_BYTE, 8'h00);
    send_item(OP_KEY_BYTE, 8'hFF);
    send_item(OP_KEY_BYTE, "Z");
    send_item(OP_KEY_BYTE, "y");
    send_item(OP_END_KEY, 8'h00);
    send_item(OP_KEY_BYTE, "Q");
    send_item(OPCODE_W'(int'(OP_END_MSG) + 1), "A");
    send_item(OPCODE_W'((1 << OPCODE_W) - 1), 8'hFF);
    send_item(OP_END_MSG, 8'h00);
    send_item(OP_PLAINTEXT, "a");
    send_item(OP_PLAINTEXT, "a");
    send_item(OP_PLAINTEXT, "j");
    send_item(OP_PLAINTEXT, "J");
    send_item(OP_PLAINTEXT, "i");
    send_item(OP_PLAINTEXT, 8'hFF);
    send_item(OP_END_MSG, 8'hFF);
    send_item(OP_PLAINTEXT, "z");
    send_item(OP_PLAINTEXT, "Y");
    send_item(OP_PLAINTEXT, "K");
    send_item(OP_PLAINTEXT, "a");
    send_item(OP_START_KEY, 8'h00);
    send_item(OP_PLAINTEXT, "b");
    send_item(OP_PLAINTEXT, "c");
    send_item(OP_END_KEY, 8'hFF);
  endtask

  task automatic test_random_sessions(input int target);
    int first;
    first = items_sent;
    while (items_sent - first < target) begin
      if ($urandom_range(0, 3) == 0) send_random_key();
      repeat ($urandom_range(1, 3)) send_random_message();
      if ($urandom_range(0, 7) == 0) send_item(undefined_opcode(), random_byte());
    end
  endtask

  task automatic test_pause_until_drained();
    send_item(OP_PLAINTEXT, "q");
    send_item(OP_PLAINTEXT, "Q");
    send_item(OP_PLAINTEXT, "r");
    hold_off_until_drained();
    send_item(OP_END_MSG, 8'h00);
    hold_off_until_drained();
    send_random_message();
  endtask

  task automatic test_unpaced_tail();
    idle_on = 1'b0;
    test_random_sessions(150);
  endtask

  initial begin : sink_stalls
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_cipher
    cipher_t want;
    if (m_tvalid_o && m_tready_i) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected output transaction: cipher_letter %0d", m_tdata_o);
        error_count++;
      end else begin
        want = cipher_q.pop_front();
        if (m_tdata_o !== {{(BYTE_W - LETTER_W){1'b0}}, want.letter}) begin
          $error("cipher_letter: expected %0d, got %0d", want.letter, m_tdata_o);
          error_count++;
        end
        if (m_tlast_o !== want.last) begin
          $error("last_of_pair: expected %0b, got %0b", want.last, m_tlast_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_sessions(450);
    test_pause_until_drained();
    test_random_sessions(450);
    test_unpaced_tail();
    hold_off_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
